/* hdl/tbeq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tbeq_pkg;

	// Band weights are unsigned Q1.15; one full weight is 32768.
	localparam int WEIGHT_W = 16;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;

	// Band edges in Q16.4 hertz.
	localparam logic [19:0] LOW_EDGE_Q4  = 20'd3200;
	localparam logic [19:0] HIGH_EDGE_Q4 = 20'd30400;

	// Reciprocals of 50 and 100 in Q20, applied with a right shift of 9.
	localparam logic [14:0] RECIP50_Q20  = 15'd20972;
	localparam logic [14:0] RECIP100_Q20 = 15'd10486;
	localparam int RECIP_SHIFT = 9;
	localparam int SLOPE_PROD_W = 35;

	localparam int GAIN_SHIFT = 27;

	// Configuration register indexes.
	localparam logic [7:0] REG_LOW_GAIN  = 8'd0;
	localparam logic [7:0] REG_MID_GAIN  = 8'd1;
	localparam logic [7:0] REG_HIGH_GAIN = 8'd2;
	localparam logic [7:0] REG_FIRST_BIN = 8'd3;
	localparam logic [7:0] REG_LAST_BIN  = 8'd4;

	typedef logic [WEIGHT_W-1:0] weight_t;

	// Load enables for the two weight stages.
	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} weight_ctrl_t;

endpackage

`default_nettype wire

/* hdl/three_band_eq_gain_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata: bin_index, bin_frequency, bin_magnitude
// m_        out        m_tvalid / m_tready   m_tdata: scaled_magnitude; m_tuser: saturated
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Six register stages: slope products, band weights, gain products, gain sum,
// magnitude product, output register. One item per cycle enters while s_tready
// is high, and a stall on m_tready can take it low. The magnitude-by-gain
// multiplier in stage five sets the critical path. Reset clears the valid bits
// and loads the register defaults. A stall holds each occupied stage, while
// empty stages ahead of it keep filling.

module three_band_eq_gain_core #(
	parameter int MAX_BINS = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // bin_index[11:0], bin_frequency[31:12], bin_magnitude[63:32]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // scaled_magnitude[31:0]
	output logic [0:0]  m_tuser,   // saturated[0]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import tbeq_pkg::*;

	localparam logic [16:0] TOP_MAX = 17'(MAX_BINS - 1);

	logic [15:0] low_gain_q;
	logic [15:0] mid_gain_q;
	logic [15:0] high_gain_q;
	logic [11:0] first_bin_q;
	logic [11:0] last_bin_q;

	logic [11:0] bin_index;
	logic [19:0] bin_frequency;
	logic [31:0] bin_magnitude;
	logic [16:0] win_top;
	logic        in_window;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic        win_s1, win_s2, win_s3, win_s4, win_s5;
	logic [31:0] mag_s1, mag_s2, mag_s3, mag_s4, mag_s5;

	weight_ctrl_t wctrl;
	weight_t      low_w_s2;
	weight_t      mid_w_s2;
	weight_t      high_w_s2;

	logic [31:0] low_term_s3;
	logic [31:0] mid_term_s3;
	logic [31:0] high_term_s3;
	logic [33:0] gain_sum;
	logic [30:0] gain_s4;
	logic [62:0] prod_s5;

	logic [31:0] scaled_s6;
	logic        sat_s6;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_gain_q  <= 16'd4096;
			mid_gain_q  <= 16'd4096;
			high_gain_q <= 16'd4096;
			first_bin_q <= 12'd0;
			last_bin_q  <= 12'd4095;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_GAIN:  low_gain_q  <= cfg_data;
				REG_MID_GAIN:  mid_gain_q  <= cfg_data;
				REG_HIGH_GAIN: high_gain_q <= cfg_data;
				REG_FIRST_BIN: first_bin_q <= cfg_data[11:0];
				REG_LAST_BIN:  last_bin_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Handshake: a stage loads when it is empty or its successor moves on.
	assign rdy6 = !v_s6 || m_tready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// Window test; the top is limited to the last bin of the frame.
	assign bin_index     = s_tdata[11:0];
	assign bin_frequency = s_tdata[31:12];
	assign bin_magnitude = s_tdata[63:32];

	assign win_top   = ({5'd0, last_bin_q} > TOP_MAX) ? TOP_MAX : {5'd0, last_bin_q};
	assign in_window = (bin_index >= first_bin_q) && ({5'd0, bin_index} <= win_top);

	// Stages 1 and 2.
	assign wctrl.load_s1 = rdy1;
	assign wctrl.load_s2 = rdy2;

	tbeq_weights u_weights (
		.clk       (clk),
		.ctrl      (wctrl),
		.frequency (bin_frequency),
		.low_w_s2  (low_w_s2),
		.mid_w_s2  (mid_w_s2),
		.high_w_s2 (high_w_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			win_s1 <= in_window;
			mag_s1 <= bin_magnitude;
		end
		if (rdy2) begin
			win_s2 <= win_s1;
			mag_s2 <= mag_s1;
		end
	end

	// Stage 3: weight times gain for each band.
	always_ff @(posedge clk) begin
		if (rdy3) begin
			win_s3       <= win_s2;
			mag_s3       <= mag_s2;
			low_term_s3  <= 32'(low_w_s2) * 32'(low_gain_q);
			mid_term_s3  <= 32'(mid_w_s2) * 32'(mid_gain_q);
			high_term_s3 <= 32'(high_w_s2) * 32'(high_gain_q);
		end
	end

	// Stage 4: combined gain. The weights sum to at most one, so it fits 31 bits.
	assign gain_sum = 34'(low_term_s3) + 34'(mid_term_s3) + 34'(high_term_s3);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			win_s4  <= win_s3;
			mag_s4  <= mag_s3;
			gain_s4 <= gain_sum[30:0];
		end
	end

	// Stage 5: magnitude times combined gain.
	always_ff @(posedge clk) begin
		if (rdy5) begin
			win_s5  <= win_s4;
			mag_s5  <= mag_s4;
			prod_s5 <= 63'(mag_s4) * 63'(gain_s4);
		end
	end

	// Stage 6: drop the gain fraction and saturate; bins outside pass through.
	always_ff @(posedge clk) begin
		if (rdy6) begin
			if (!win_s5) begin
				scaled_s6 <= mag_s5;
				sat_s6    <= 1'b0;
			end else if (|prod_s5[62:GAIN_SHIFT+32]) begin
				scaled_s6 <= 32'hFFFF_FFFF;
				sat_s6    <= 1'b1;
			end else begin
				scaled_s6 <= prod_s5[GAIN_SHIFT+31:GAIN_SHIFT];
				sat_s6    <= 1'b0;
			end
		end
	end

	assign m_tvalid   = v_s6;
	assign m_tdata    = scaled_s6;
	assign m_tuser[0] = sat_s6;

endmodule

`default_nettype wire

/* hdl/tbeq_weights.sv */
`timescale 1ns / 1ps
`default_nettype none

module tbeq_weights (
	input  wire                   clk,
	input  tbeq_pkg::weight_ctrl_t ctrl,
	input  wire  [19:0]           frequency,
	output tbeq_pkg::weight_t     low_w_s2,
	output tbeq_pkg::weight_t     mid_w_s2,
	output tbeq_pkg::weight_t     high_w_s2
);
	import tbeq_pkg::*;

	logic                    low_full_s1;
	logic                    high_none_s1;
	logic [SLOPE_PROD_W-1:0] low_prod_s1;
	logic [SLOPE_PROD_W-1:0] high_prod_s1;

	logic [19:0] low_dist;
	logic [19:0] high_dist;
	logic [SLOPE_PROD_W-RECIP_SHIFT-1:0] low_drop;
	logic [SLOPE_PROD_W-RECIP_SHIFT-1:0] high_rise;
	weight_t low_w;
	weight_t high_w;
	logic [WEIGHT_W:0] side_sum;
	weight_t mid_w;

	assign low_dist  = frequency - LOW_EDGE_Q4;
	assign high_dist = frequency - HIGH_EDGE_Q4;

	// Stage 1: distance past each edge times the slope reciprocal.
	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			low_full_s1  <= (frequency <= LOW_EDGE_Q4);
			high_none_s1 <= (frequency <= HIGH_EDGE_Q4);
			low_prod_s1  <= SLOPE_PROD_W'(low_dist) * SLOPE_PROD_W'(RECIP50_Q20);
			high_prod_s1 <= SLOPE_PROD_W'(high_dist) * SLOPE_PROD_W'(RECIP100_Q20);
		end
	end

	assign low_drop  = low_prod_s1[SLOPE_PROD_W-1:RECIP_SHIFT];
	assign high_rise = high_prod_s1[SLOPE_PROD_W-1:RECIP_SHIFT];

	always_comb begin
		if (low_full_s1) begin
			low_w = WEIGHT_ONE;
		end else if (low_drop >= 26'(WEIGHT_ONE)) begin
			low_w = '0;
		end else begin
			low_w = WEIGHT_ONE - WEIGHT_W'(low_drop);
		end

		if (high_none_s1) begin
			high_w = '0;
		end else if (high_rise > 26'(WEIGHT_ONE)) begin
			high_w = WEIGHT_ONE;
		end else begin
			high_w = WEIGHT_W'(high_rise);
		end

		// The mid weight takes what the outer bands leave, never below zero.
		side_sum = {1'b0, low_w} + {1'b0, high_w};
		if (side_sum >= {1'b0, WEIGHT_ONE}) begin
			mid_w = '0;
		end else begin
			mid_w = WEIGHT_ONE - side_sum[WEIGHT_W-1:0];
		end
	end

	// Stage 2: the three weights.
	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			low_w_s2  <= low_w;
			mid_w_s2  <= mid_w;
			high_w_s2 <= high_w;
		end
	end

endmodule

`default_nettype wire
